// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, disabled in reset
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed: label");

// condition that must never be seen on a rising clock edge out of reset
`define ASSERT_NEVER(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(prop)) \
        else $error("assertion failed: label");

`endif

// ===== rtl/pwsa_pkg.sv =====
// package for the perspective warp source address block
// widths, register indexes and shared types; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pwsa_pkg;
    localparam int OutWidth  = 1024;
    localparam int OutHeight = 2048;
    localparam int SrcDimMax = 4096;
    localparam int XW   = 10;
    localparam int YW   = 11;
    localparam int CW   = 32;
    localparam int SW   = 46;   // signed sum width
    localparam int MW   = 45;   // magnitude width
    localparam int QW   = 12;   // quotient bits kept
    localparam int NQ   = QW + 1;   // quotient bits computed
    localparam int QIW  = 4;    // quotient bit index width
    localparam int DW   = MW + NQ;  // shifted divisor width
    localparam int BW   = 13;   // bound width
    localparam int ADW  = 6;    // apb address width

    localparam logic [2:0] RegM00M01 = 3'd0;
    localparam logic [2:0] RegM02M10 = 3'd1;
    localparam logic [2:0] RegM11M12 = 3'd2;
    localparam logic [2:0] RegM20M21 = 3'd3;
    localparam logic [2:0] RegM22    = 3'd4;
    localparam logic [2:0] RegSrcW   = 3'd5;
    localparam logic [2:0] RegSrcH   = 3'd6;

    typedef struct packed {
        logic signed [CW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
        logic [BW-1:0]        bnd_x;
        logic [BW-1:0]        bnd_y;
    } t_cfg;

    // divider stage payload
    typedef struct packed {
        logic          vld;
        logic          ok;
        logic [MW-1:0] rem_x;
        logic [MW-1:0] rem_y;
        logic [MW-1:0] den;
        logic [NQ-1:0] q_x;
        logic [NQ-1:0] q_y;
        logic          neg_x;
        logic          neg_y;
        logic [BW-1:0] bnd_x;
        logic [BW-1:0] bnd_y;
    } t_div;
endpackage
`default_nettype wire

// ===== rtl/perspective_warp_source_address.sv =====
// top level of the perspective warp source address block
// depends on pwsa_pkg, pwsa_regs, pwsa_mac, pwsa_div_stage, assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// One output pixel coordinate per clock is taken (o_busy is always low) and its
// source address appears on o_src_x/o_src_y/o_inside_res with o_done after
// three multiply/sum stages, thirteen restoring divider stages (quotient bits
// 12..0, a bit of each axis per stage) and a result register. The
// receiver cannot stall, so every transaction must be taken when o_done is high.
// Write configuration only while no transaction is in flight.
module perspective_warp_source_address (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    output logic                           o_busy,
    input  wire logic [pwsa_pkg::XW-1:0]   i_out_x,
    input  wire logic [pwsa_pkg::YW-1:0]   i_out_y,
    output logic                           o_done,
    output logic [pwsa_pkg::QW-1:0]        o_src_x,
    output logic [pwsa_pkg::QW-1:0]        o_src_y,
    output logic                           o_inside_res,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [pwsa_pkg::ADW-1:0]  paddr,
    input  wire logic [63:0]               pwdata,
    output logic      [63:0]               prdata,
    output logic                           pready
);
    localparam int NB = pwsa_pkg::NQ;
    pwsa_pkg::t_cfg cfg;
    pwsa_pkg::t_div chain [NB+1];
    logic r_done, r_in;
    logic [pwsa_pkg::QW-1:0] r_sx, r_sy;
    logic in_n;
    pwsa_pkg::t_div fin;

    assign o_busy = 1'b0;

    pwsa_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(cfg)
    );

    pwsa_mac u_mac (
        .i_clk, .i_rst_n, .i_vld(i_start), .i_x(i_out_x), .i_y(i_out_y),
        .i_cfg(cfg), .o_div(chain[0])
    );

    for (genvar g = 0; g < NB; g++) begin : g_div
        pwsa_div_stage u_st (
            .i_clk, .i_rst_n, .i_bit(pwsa_pkg::QIW'(NB-1-g)),
            .i_div(chain[g]), .o_div(chain[g+1])
        );
    end

    assign fin  = chain[NB];
    // a quotient beyond the computed bits leaves the remainder at or above the divisor
    assign in_n = fin.ok
                  && !(fin.neg_x && fin.q_x != '0) && !(fin.neg_y && fin.q_y != '0)
                  && ({1'b0, fin.q_x} < {1'b0, fin.bnd_x})
                  && ({1'b0, fin.q_y} < {1'b0, fin.bnd_y})
                  && !(fin.rem_x >= fin.den) && !(fin.rem_y >= fin.den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= fin.vld;
        r_in <= in_n;
        r_sx <= in_n ? fin.q_x[pwsa_pkg::QW-1:0] : '0;
        r_sy <= in_n ? fin.q_y[pwsa_pkg::QW-1:0] : '0;
    end

    assign o_done       = r_done;
    assign o_src_x      = r_sx;
    assign o_src_y      = r_sy;
    assign o_inside_res = r_in;

    `ASSERT_CLK(a_outside_zero, (o_done && !o_inside_res) |-> (o_src_x == '0 && o_src_y == '0))
    `ASSERT_CLK(a_latency, i_start |-> ##17 o_done)
    `ASSERT_NEVER(a_never_busy, o_busy)
endmodule
`default_nettype wire

// ===== rtl/pwsa_regs.sv =====
// apb register file for the warp coefficients and source bounds
// depends on pwsa_pkg
`timescale 1ns / 1ps
`default_nettype none
module pwsa_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [pwsa_pkg::ADW-1:0]  paddr,
    input  wire logic [63:0]               pwdata,
    output logic      [63:0]               prdata,
    output logic                           pready,
    output pwsa_pkg::t_cfg                 o_cfg
);
    logic [63:0] r_r0, r_r1, r_r2, r_r3;
    logic [31:0] r_r4;
    logic [pwsa_pkg::BW-1:0] r_w, r_h;
    logic [2:0] idx;
    logic [pwsa_pkg::BW-1:0] cw, ch;

    assign idx    = paddr[5:3];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r0 <= '0; r_r1 <= '0; r_r2 <= '0; r_r3 <= '0; r_r4 <= '0;
            r_w  <= 13'd4096; r_h <= 13'd4096;
        end else if (psel && penable && pwrite) begin
            case (idx)
                pwsa_pkg::RegM00M01: r_r0 <= pwdata;
                pwsa_pkg::RegM02M10: r_r1 <= pwdata;
                pwsa_pkg::RegM11M12: r_r2 <= pwdata;
                pwsa_pkg::RegM20M21: r_r3 <= pwdata;
                pwsa_pkg::RegM22:    r_r4 <= pwdata[31:0];
                pwsa_pkg::RegSrcW:   r_w  <= pwdata[12:0];
                pwsa_pkg::RegSrcH:   r_h  <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            pwsa_pkg::RegM00M01: prdata = r_r0;
            pwsa_pkg::RegM02M10: prdata = r_r1;
            pwsa_pkg::RegM11M12: prdata = r_r2;
            pwsa_pkg::RegM20M21: prdata = r_r3;
            pwsa_pkg::RegM22:    prdata = {32'd0, r_r4};
            pwsa_pkg::RegSrcW:   prdata = {51'd0, r_w};
            pwsa_pkg::RegSrcH:   prdata = {51'd0, r_h};
            default:             prdata = '0;
        endcase
    end

    assign cw = (r_w > 13'(pwsa_pkg::SrcDimMax)) ? 13'(pwsa_pkg::SrcDimMax) : r_w;
    assign ch = (r_h > 13'(pwsa_pkg::SrcDimMax)) ? 13'(pwsa_pkg::SrcDimMax) : r_h;

    always_comb begin
        o_cfg.m00   = r_r0[63:32];
        o_cfg.m01   = r_r0[31:0];
        o_cfg.m02   = r_r1[63:32];
        o_cfg.m10   = r_r1[31:0];
        o_cfg.m11   = r_r2[63:32];
        o_cfg.m12   = r_r2[31:0];
        o_cfg.m20   = r_r3[63:32];
        o_cfg.m21   = r_r3[31:0];
        o_cfg.m22   = r_r4;
        o_cfg.bnd_x = cw;
        o_cfg.bnd_y = ch;
    end
endmodule
`default_nettype wire

// ===== rtl/pwsa_mac.sv =====
// three-stage projective sums: products, then sums, then magnitudes
// depends on pwsa_pkg
`timescale 1ns / 1ps
`default_nettype none
module pwsa_mac (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_vld,
    input  wire logic [pwsa_pkg::XW-1:0]   i_x,
    input  wire logic [pwsa_pkg::YW-1:0]   i_y,
    input  pwsa_pkg::t_cfg                 i_cfg,
    output pwsa_pkg::t_div                 o_div
);
    localparam int PW = pwsa_pkg::CW + pwsa_pkg::YW + 1;
    logic r_v1, r_v2, r_ok1, r_ok2;
    logic signed [PW-1:0] r_p [9];
    logic signed [pwsa_pkg::SW-1:0] r_nx, r_ny, r_d;
    logic signed [pwsa_pkg::XW:0] sx;
    logic signed [pwsa_pkg::YW:0] sy;
    logic ok_in;
    pwsa_pkg::t_div n_div, r_div;

    assign sx    = {1'b0, i_x};
    assign sy    = {1'b0, i_y};
    assign ok_in = (32'(i_x) < 32'(pwsa_pkg::OutWidth)) && (32'(i_y) < 32'(pwsa_pkg::OutHeight));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_vld; r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok1 <= ok_in;
        r_p[0] <= PW'(i_cfg.m00 * sx);
        r_p[1] <= PW'(i_cfg.m01 * sy);
        r_p[2] <= PW'(i_cfg.m02);
        r_p[3] <= PW'(i_cfg.m10 * sx);
        r_p[4] <= PW'(i_cfg.m11 * sy);
        r_p[5] <= PW'(i_cfg.m12);
        r_p[6] <= PW'(i_cfg.m20 * sx);
        r_p[7] <= PW'(i_cfg.m21 * sy);
        r_p[8] <= PW'(i_cfg.m22);
        r_ok2 <= r_ok1;
        r_nx <= pwsa_pkg::SW'(r_p[0]) + pwsa_pkg::SW'(r_p[1]) + pwsa_pkg::SW'(r_p[2]);
        r_ny <= pwsa_pkg::SW'(r_p[3]) + pwsa_pkg::SW'(r_p[4]) + pwsa_pkg::SW'(r_p[5]);
        r_d  <= pwsa_pkg::SW'(r_p[6]) + pwsa_pkg::SW'(r_p[7]) + pwsa_pkg::SW'(r_p[8]);
    end

    always_comb begin
        logic [pwsa_pkg::SW-1:0] ax, ay, ad;
        ax = r_nx[pwsa_pkg::SW-1] ? pwsa_pkg::SW'(-r_nx) : pwsa_pkg::SW'(r_nx);
        ay = r_ny[pwsa_pkg::SW-1] ? pwsa_pkg::SW'(-r_ny) : pwsa_pkg::SW'(r_ny);
        ad = r_d[pwsa_pkg::SW-1]  ? pwsa_pkg::SW'(-r_d)  : pwsa_pkg::SW'(r_d);
        n_div       = '0;
        n_div.vld   = r_v2;
        n_div.ok    = r_ok2 && (r_d != '0);
        n_div.rem_x = ax[pwsa_pkg::MW-1:0];
        n_div.rem_y = ay[pwsa_pkg::MW-1:0];
        n_div.den   = ad[pwsa_pkg::MW-1:0];
        n_div.neg_x = r_nx[pwsa_pkg::SW-1] ^ r_d[pwsa_pkg::SW-1];
        n_div.neg_y = r_ny[pwsa_pkg::SW-1] ^ r_d[pwsa_pkg::SW-1];
        n_div.bnd_x = i_cfg.bnd_x;
        n_div.bnd_y = i_cfg.bnd_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_div.vld <= 1'b0;
        else          r_div.vld <= n_div.vld;
        r_div.ok    <= n_div.ok;
        r_div.rem_x <= n_div.rem_x;
        r_div.rem_y <= n_div.rem_y;
        r_div.den   <= n_div.den;
        r_div.q_x   <= n_div.q_x;
        r_div.q_y   <= n_div.q_y;
        r_div.neg_x <= n_div.neg_x;
        r_div.neg_y <= n_div.neg_y;
        r_div.bnd_x <= n_div.bnd_x;
        r_div.bnd_y <= n_div.bnd_y;
    end

    assign o_div = r_div;
endmodule
`default_nettype wire

// ===== rtl/pwsa_div_stage.sv =====
// one restoring-division stage producing one quotient bit for each axis
// depends on pwsa_pkg
`timescale 1ns / 1ps
`default_nettype none
module pwsa_div_stage (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [pwsa_pkg::QIW-1:0]  i_bit,
    input  pwsa_pkg::t_div                 i_div,
    output pwsa_pkg::t_div                 o_div
);
    pwsa_pkg::t_div n_div, r_div;

    always_comb begin
        logic [pwsa_pkg::DW-1:0] sd;
        logic [pwsa_pkg::DW-1:0] rx, ry;
        sd = pwsa_pkg::DW'(i_div.den) << i_bit;
        rx = pwsa_pkg::DW'(i_div.rem_x);
        ry = pwsa_pkg::DW'(i_div.rem_y);
        n_div = i_div;
        if (rx >= sd) begin
            n_div.rem_x  = pwsa_pkg::MW'(rx - sd);
            n_div.q_x[i_bit] = 1'b1;
        end
        if (ry >= sd) begin
            n_div.rem_y  = pwsa_pkg::MW'(ry - sd);
            n_div.q_y[i_bit] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_div.vld <= 1'b0;
        else          r_div.vld <= n_div.vld;
        r_div.ok    <= n_div.ok;
        r_div.rem_x <= n_div.rem_x;
        r_div.rem_y <= n_div.rem_y;
        r_div.den   <= n_div.den;
        r_div.q_x   <= n_div.q_x;
        r_div.q_y   <= n_div.q_y;
        r_div.neg_x <= n_div.neg_x;
        r_div.neg_y <= n_div.neg_y;
        r_div.bnd_x <= n_div.bnd_x;
        r_div.bnd_y <= n_div.bnd_y;
    end

    assign o_div = r_div;
endmodule
`default_nettype wire
